[rtl/slt_pkg.sv]
`timescale 1ns / 1ps

package slt_pkg;

	localparam int MaxResults = 3;
	localparam int CountWidth = $clog2(MaxResults + 1);

	localparam logic [7:0] CharAmp    = 8'h26;
	localparam logic [7:0] CharPipe   = 8'h7C;
	localparam logic [7:0] CharSemi   = 8'h3B;
	localparam logic [7:0] CharGt     = 8'h3E;
	localparam logic [7:0] CharLt     = 8'h3C;
	localparam logic [7:0] CharLparen = 8'h28;
	localparam logic [7:0] CharRparen = 8'h29;
	localparam logic [7:0] CharQuote  = 8'h22;
	localparam logic [7:0] CharSpace  = 8'h20;

	typedef struct packed {
		logic       has_char;
		logic [7:0] char_out;
		logic       token_end;
		logic       line_done;
	} slt_item_t;

	typedef struct packed {
		logic       in_quotes;
		logic       after_space;
		logic       after_special;
		logic       word_nonempty;
		logic       at_line_start;
		logic       held_valid;
		logic [7:0] held_char;
	} slt_state_t;

	typedef struct packed {
		logic [CountWidth-1:0]        count;
		slt_item_t [MaxResults-1:0]   items;
	} slt_bundle_t;

	localparam slt_state_t StateReset = '{
		in_quotes:     1'b0,
		after_space:   1'b0,
		after_special: 1'b0,
		word_nonempty: 1'b0,
		at_line_start: 1'b1,
		held_valid:    1'b0,
		held_char:     8'h00
	};

	function automatic logic is_special(input logic [7:0] c);
		return c inside {CharAmp, CharPipe, CharSemi, CharGt, CharLt, CharLparen, CharRparen};
	endfunction

	function automatic logic is_pair_second(input logic [7:0] c);
		return c inside {CharAmp, CharPipe, CharGt};
	endfunction

	function automatic slt_item_t mk_item(input logic has, input logic [7:0] ch,
			input logic tend, input logic done);
		slt_item_t it;
		it.has_char  = has;
		it.char_out  = has ? ch : 8'h00;
		it.token_end = tend;
		it.line_done = done;
		return it;
	endfunction

endpackage

[rtl/slt_decode.sv]
`timescale 1ns / 1ps

module slt_decode import slt_pkg::*; (
	input  slt_state_t  state,
	input  logic [7:0]  char_in,
	input  logic        end_of_line,
	output slt_state_t  state_next,
	output slt_bundle_t bundle
);

	slt_state_t            ns;
	slt_item_t [MaxResults-1:0] items;
	logic [CountWidth-1:0] n;

	always_comb begin
		ns    = state;
		items = '0;
		n     = '0;
		if (end_of_line) begin
			if (state.held_valid) begin
				items[n] = mk_item(1'b1, state.held_char, 1'b0, 1'b0);
				n = n + 1'b1;
				items[n] = mk_item(1'b0, 8'h00, 1'b1, 1'b0);
				n = n + 1'b1;
			end
			if (!state.after_space && !state.after_special) begin
				items[n] = mk_item(1'b0, 8'h00, 1'b1, 1'b0);
				n = n + 1'b1;
			end
			items[n] = mk_item(1'b0, 8'h00, 1'b0, 1'b1);
			n = n + 1'b1;
			ns = StateReset;
		end else if (state.held_valid && is_pair_second(char_in)) begin
			// join the held special and this byte into one two-character token
			items[n] = mk_item(1'b1, state.held_char, 1'b0, 1'b0);
			n = n + 1'b1;
			items[n] = mk_item(1'b1, char_in, 1'b0, 1'b0);
			n = n + 1'b1;
			items[n] = mk_item(1'b0, 8'h00, 1'b1, 1'b0);
			n = n + 1'b1;
			ns.held_valid    = 1'b0;
			ns.held_char     = 8'h00;
			ns.after_special = 1'b1;
			ns.at_line_start = 1'b0;
		end else begin
			if (state.held_valid) begin
				items[n] = mk_item(1'b1, state.held_char, 1'b0, 1'b0);
				n = n + 1'b1;
				items[n] = mk_item(1'b0, 8'h00, 1'b1, 1'b0);
				n = n + 1'b1;
				ns.held_valid = 1'b0;
				ns.held_char  = 8'h00;
			end
			if (char_in == CharSpace && !ns.in_quotes) begin
				if (!ns.after_space) begin
					ns.after_space = 1'b1;
					if (ns.word_nonempty) begin
						items[n] = mk_item(1'b0, 8'h00, 1'b1, 1'b0);
						n = n + 1'b1;
					end
					ns.word_nonempty = 1'b0;
				end
			end else if (is_special(char_in)) begin
				if (!ns.at_line_start && !ns.after_space && !ns.after_special) begin
					items[n] = mk_item(1'b0, 8'h00, 1'b1, 1'b0);
					n = n + 1'b1;
				end
				ns.word_nonempty = 1'b0;
				ns.held_valid    = 1'b1;
				ns.held_char     = char_in;
				ns.after_special = 1'b1;
			end else begin
				ns.after_space   = 1'b0;
				ns.after_special = 1'b0;
				if (char_in == CharQuote) begin
					ns.in_quotes = !ns.in_quotes;
				end else begin
					items[n] = mk_item(1'b1, char_in, 1'b0, 1'b0);
					n = n + 1'b1;
					ns.word_nonempty = 1'b1;
				end
			end
			ns.at_line_start = 1'b0;
		end
	end

	assign state_next    = ns;
	assign bundle.count  = n;
	assign bundle.items  = items;

endmodule

[rtl/slt_result_buf.sv]
`timescale 1ns / 1ps

module slt_result_buf import slt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  slt_bundle_t bundle,
	output logic        free,
	output logic        out_valid,
	input  logic        out_ready,
	output slt_item_t   item,
	output logic        item_last
);

	logic                  valid_q;
	logic [CountWidth-1:0] idx_q;
	slt_bundle_t           bundle_q;
	logic                  take;
	logic                  at_last;

	assign at_last   = (idx_q == bundle_q.count - 1'b1);
	assign take      = valid_q && out_ready;
	assign free      = !valid_q || (take && at_last);
	assign out_valid = valid_q;
	assign item      = bundle_q.items[idx_q[$clog2(MaxResults)-1:0]];
	assign item_last = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= (bundle.count != '0);
			idx_q   <= '0;
		end else if (take && at_last) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// payload: hold until the next bundle loads
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

endmodule

[rtl/shell_line_tokenizer_top.sv]
`timescale 1ns / 1ps

// Streaming shell tokenizer: one command-line byte (or an end-of-line mark)
// per input word, token characters and token-end marks out, one result word
// per output word. Each input word is decoded in the cycle it is accepted;
// its zero to three result words land together in a result buffer that
// drains one word per cycle while out_ready is high. A byte that yields at
// most one result word therefore lets back-to-back input run at full rate as
// long as the output side is ready; a word that yields more holds off the next
// input until its last result word is taken. in_ready is high while the buffer
// is empty or its final result word is taken in the same cycle, so it follows
// out_ready combinationally. A special character (& | ; > < ( )) is held
// back for one word to see whether it pairs into &&, ||, >> and so on; the
// end-of-line word flushes it. Every line ends in a result word with
// line_done set, and last marks the final result word of each input word.

module shell_line_tokenizer_top import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       has_char,
	output logic [7:0] char_out,
	output logic       token_end,
	output logic       line_done,
	output logic       last
);

	slt_state_t  state_q;
	slt_state_t  state_next;
	slt_bundle_t bundle;
	slt_item_t   item;
	logic        free;
	logic        accept;

	assign in_ready = free;
	assign accept   = in_valid && free;

	// decode one word against the line state
	slt_decode u_decode (
		.state       (state_q),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.state_next  (state_next),
		.bundle      (bundle)
	);

	// line state advances only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	// hold the result words and hand them out one at a time
	slt_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.item      (item),
		.item_last (last)
	);

	assign has_char  = item.has_char;
	assign char_out  = item.char_out;
	assign token_end = item.token_end;
	assign line_done = item.line_done;

endmodule

[rtl/slt_checker.sv]
`timescale 1ns / 1ps

module slt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       has_char,
	input logic [7:0] char_out,
	input logic       token_end,
	input logic       line_done,
	input logic       last
);

	// a token-end word never carries a character
	a_tend_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_end |-> !has_char)
		else $error("token_end word carries a character");

	// line done closes the results of its input word and carries nothing else
	a_done_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last && !has_char && !token_end)
		else $error("line_done word malformed");

	// a word without a character shows zero on char_out
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> char_out == 8'h00)
		else $error("char_out not zero without has_char");

	// every result word carries something
	a_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char && !token_end |-> line_done)
		else $error("empty result word");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last))
		else $error("stalled result word changed");

endmodule

bind shell_line_tokenizer_top slt_checker u_slt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.has_char  (has_char),
	.char_out  (char_out),
	.token_end (token_end),
	.line_done (line_done),
	.last      (last)
);
